FILE: design/midi_cc_to_synth_params_assert.svh
// Assertion macros for the MIDI control-change parser.
// All macros sample on clk and are disabled while rst_n is low.
`ifndef MIDI_CC_TO_SYNTH_PARAMS_ASSERT_SVH
`define MIDI_CC_TO_SYNTH_PARAMS_ASSERT_SVH

// Same-cycle implication
`define MCCSP_ASSERT_NOW(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// Next-cycle implication
`define MCCSP_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`endif

FILE: design/mccsp_pkg.sv
package mccsp_pkg;

    typedef logic [4:0] action_t;

    // Result actions
    localparam action_t ACT_VOLUME      = 5'd0;  // base, plus voice 0..3
    localparam action_t ACT_DUTY        = 5'd4;  // base, plus voice 0..2
    localparam action_t ACT_NOISE_RATIO = 5'd7;
    localparam action_t ACT_FREQ        = 5'd8;  // base, plus voice 0..2
    localparam action_t ACT_NOISE_FREQ  = 5'd11;
    localparam action_t ACT_WAVE_NEXT   = 5'd12;
    localparam action_t ACT_NOISE_STEP  = 5'd13;
    localparam action_t ACT_WAVE_RANGE  = 5'd14;
    localparam action_t ACT_REWIND      = 5'd15;
    localparam action_t ACT_SEQ_RUN     = 5'd16;
    localparam action_t ACT_CHORD_MODE  = 5'd17;
    localparam action_t ACT_CHORD_SLOT  = 5'd18;

    // Control-change numbers
    localparam logic [6:0] CC_VOL_FIRST    = 7'd1;
    localparam logic [6:0] CC_VOL_LAST     = 7'd4;
    localparam logic [6:0] CC_DUTY_FIRST   = 7'd5;
    localparam logic [6:0] CC_DUTY_LAST    = 7'd7;
    localparam logic [6:0] CC_NOISE_RATIO  = 7'd8;
    localparam logic [6:0] CC_COARSE_FIRST = 7'd9;
    localparam logic [6:0] CC_COARSE_LAST  = 7'd11;
    localparam logic [6:0] CC_NOISE_FREQ   = 7'd12;
    localparam logic [6:0] CC_FINE_FIRST   = 7'd13;
    localparam logic [6:0] CC_FINE_LAST    = 7'd15;
    localparam logic [6:0] CC_WAVE_NEXT    = 7'd19;
    localparam logic [6:0] CC_NOISE_STEP   = 7'd20;
    localparam logic [6:0] CC_MUTE_FIRST   = 7'd21;
    localparam logic [6:0] CC_MUTE_LAST    = 7'd24;
    localparam logic [6:0] CC_WAVE_RANGE   = 7'd27;
    localparam logic [6:0] CC_REWIND       = 7'd29;
    localparam logic [6:0] CC_SEQ_RUN      = 7'd32;
    localparam logic [6:0] CC_CHORD_MODE   = 7'd33;

    // Status nibbles
    localparam logic [3:0] KIND_NOTE_ON = 4'h9;
    localparam logic [3:0] KIND_CC      = 4'hB;
    localparam logic [3:0] KIND_SYSTEM  = 4'hF;

    // Clamp limits and fine-tune center
    localparam logic [10:0] FREQ_MAX     = 11'd2047;
    localparam logic [6:0]  FINE_MID     = 7'd64;
    localparam logic [6:0]  VOL_MAX      = 7'd15;
    localparam logic [6:0]  DUTY_MAX     = 7'd3;
    localparam logic [6:0]  NOISE_RATIO_MAX = 7'd6;
    localparam logic [6:0]  NOISE_FREQ_MAX  = 7'd15;

    // White keys C4..C5 mapped to chord slots 0..7
    localparam int NUM_KEYS = 8;
    localparam logic [6:0] KEY_TABLE [NUM_KEYS] =
        '{7'h3C, 7'h3E, 7'h40, 7'h41, 7'h43, 7'h45, 7'h47, 7'h48};

    // One result from the parameter unit
    typedef struct packed {
        logic       hit;
        action_t    action;
        logic [10:0] value;
    } result_t;

endpackage

FILE: design/mccsp_param_unit.sv
// Parser state with control-change and note-on decode; updates state on step.
module mccsp_param_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         midi_byte,
    input  logic [3:0]         cc_channel,
    output mccsp_pkg::result_t result
);

    logic [7:0]  running_status_reg, running_status_next;
    logic [6:0]  held_address_reg, held_address_next;
    logic        captured_reg, captured_next;
    logic [10:0] coarse_reg [3];
    logic [10:0] coarse_next [3];
    logic [3:0]  volume_reg [4];
    logic [3:0]  volume_next [4];
    logic [3:0]  saved_reg [4];
    logic [3:0]  saved_next [4];

    logic [6:0]  addr;
    logic [6:0]  v;
    logic        v_nz;
    logic [1:0]  vol_idx;
    logic [1:0]  duty_idx;
    logic [1:0]  coarse_idx;
    logic [1:0]  fine_idx;
    logic [1:0]  mute_idx;
    logic [10:0] coarse_sel;
    logic [11:0] fine_up;
    logic [6:0]  fine_down;
    logic [10:0] fine_val;

    assign addr       = held_address_reg;
    assign v          = midi_byte[6:0];
    assign v_nz       = (v != 7'd0);
    assign vol_idx    = 2'(addr - mccsp_pkg::CC_VOL_FIRST);
    assign duty_idx   = 2'(addr - mccsp_pkg::CC_DUTY_FIRST);
    assign coarse_idx = 2'(addr - mccsp_pkg::CC_COARSE_FIRST);
    assign fine_idx   = 2'(addr - mccsp_pkg::CC_FINE_FIRST);
    assign mute_idx   = 2'(addr - mccsp_pkg::CC_MUTE_FIRST);

    // Fine tune: coarse plus signed offset about center, held in 0..2047
    always_comb
    begin
        coarse_sel = (fine_idx < 2'd3) ? coarse_reg[fine_idx] : 11'd0;
        fine_up    = {1'b0, coarse_sel} + 12'(v - mccsp_pkg::FINE_MID);
        fine_down  = mccsp_pkg::FINE_MID - v;
        if (v >= mccsp_pkg::FINE_MID)
        begin
            fine_val = fine_up[11] ? mccsp_pkg::FREQ_MAX : fine_up[10:0];
        end
        else
        begin
            fine_val = (coarse_sel >= 11'(fine_down)) ? coarse_sel - 11'(fine_down) : 11'd0;
        end
    end

    // Byte classification, decode and state update
    always_comb
    begin
        running_status_next = running_status_reg;
        held_address_next   = held_address_reg;
        captured_next       = captured_reg;
        coarse_next         = coarse_reg;
        volume_next         = volume_reg;
        saved_next          = saved_reg;
        result              = '0;

        if (step)
        begin
            if (midi_byte[7])
            begin
                if (midi_byte[7:4] != mccsp_pkg::KIND_SYSTEM)
                begin
                    running_status_next = midi_byte;
                    captured_next       = 1'b0;
                end
            end
            else if (!captured_reg)
            begin
                captured_next     = 1'b1;
                held_address_next = v;
            end
            else
            begin
                captured_next = 1'b0;
                if (running_status_reg[7:4] == mccsp_pkg::KIND_CC)
                begin
                    if (running_status_reg[3:0] == cc_channel)
                    begin
                        result.hit = 1'b1;
                        if (addr >= mccsp_pkg::CC_VOL_FIRST && addr <= mccsp_pkg::CC_VOL_LAST)
                        begin
                            volume_next[vol_idx] = (v > mccsp_pkg::VOL_MAX) ?
                                4'(mccsp_pkg::VOL_MAX) : v[3:0];
                            result.action = mccsp_pkg::ACT_VOLUME + 5'(vol_idx);
                            result.value  = 11'(volume_next[vol_idx]);
                        end
                        else if (addr >= mccsp_pkg::CC_DUTY_FIRST &&
                                 addr <= mccsp_pkg::CC_DUTY_LAST)
                        begin
                            result.action = mccsp_pkg::ACT_DUTY + 5'(duty_idx);
                            result.value  = (v > mccsp_pkg::DUTY_MAX) ?
                                11'(mccsp_pkg::DUTY_MAX) : 11'(v);
                        end
                        else if (addr == mccsp_pkg::CC_NOISE_RATIO)
                        begin
                            result.action = mccsp_pkg::ACT_NOISE_RATIO;
                            result.value  = (v > mccsp_pkg::NOISE_RATIO_MAX) ?
                                11'(mccsp_pkg::NOISE_RATIO_MAX) : 11'(v);
                        end
                        else if (addr >= mccsp_pkg::CC_COARSE_FIRST &&
                                 addr <= mccsp_pkg::CC_COARSE_LAST)
                        begin
                            // v*16 never exceeds the frequency limit
                            coarse_next[coarse_idx] = {v, 4'd0};
                            result.action = mccsp_pkg::ACT_FREQ + 5'(coarse_idx);
                            result.value  = {v, 4'd0};
                        end
                        else if (addr == mccsp_pkg::CC_NOISE_FREQ)
                        begin
                            result.action = mccsp_pkg::ACT_NOISE_FREQ;
                            result.value  = (v > mccsp_pkg::NOISE_FREQ_MAX) ?
                                11'(mccsp_pkg::NOISE_FREQ_MAX) : 11'(v);
                        end
                        else if (addr >= mccsp_pkg::CC_FINE_FIRST &&
                                 addr <= mccsp_pkg::CC_FINE_LAST)
                        begin
                            result.action = mccsp_pkg::ACT_FREQ + 5'(fine_idx);
                            result.value  = fine_val;
                        end
                        else if (addr >= mccsp_pkg::CC_MUTE_FIRST &&
                                 addr <= mccsp_pkg::CC_MUTE_LAST)
                        begin
                            // mute saves the volume, unmute restores it
                            if (v_nz)
                            begin
                                saved_next[mute_idx]  = volume_reg[mute_idx];
                                volume_next[mute_idx] = 4'd0;
                            end
                            else
                            begin
                                volume_next[mute_idx] = saved_reg[mute_idx];
                            end
                            result.action = mccsp_pkg::ACT_VOLUME + 5'(mute_idx);
                            result.value  = 11'(volume_next[mute_idx]);
                        end
                        else if (addr == mccsp_pkg::CC_WAVE_NEXT)
                        begin
                            result.hit    = v_nz;
                            result.action = mccsp_pkg::ACT_WAVE_NEXT;
                            result.value  = 11'd1;
                        end
                        else if (addr == mccsp_pkg::CC_NOISE_STEP)
                        begin
                            result.action = mccsp_pkg::ACT_NOISE_STEP;
                            result.value  = 11'(v_nz);
                        end
                        else if (addr == mccsp_pkg::CC_WAVE_RANGE)
                        begin
                            result.action = mccsp_pkg::ACT_WAVE_RANGE;
                            result.value  = 11'(v_nz);
                        end
                        else if (addr == mccsp_pkg::CC_REWIND)
                        begin
                            result.action = mccsp_pkg::ACT_REWIND;
                            result.value  = 11'd0;
                        end
                        else if (addr == mccsp_pkg::CC_SEQ_RUN)
                        begin
                            result.action = mccsp_pkg::ACT_SEQ_RUN;
                            result.value  = 11'(v_nz);
                        end
                        else if (addr == mccsp_pkg::CC_CHORD_MODE)
                        begin
                            result.action = mccsp_pkg::ACT_CHORD_MODE;
                            result.value  = 11'(v_nz);
                        end
                        else
                        begin
                            result.hit = 1'b0;
                        end
                    end
                end
                else if (running_status_reg[7:4] == mccsp_pkg::KIND_NOTE_ON)
                begin
                    // chord slot select, any channel, any velocity
                    for (int i = 0; i < mccsp_pkg::NUM_KEYS; i++)
                    begin
                        if (addr == mccsp_pkg::KEY_TABLE[i])
                        begin
                            result.hit    = 1'b1;
                            result.action = mccsp_pkg::ACT_CHORD_SLOT;
                            result.value  = 11'(i);
                        end
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_status_reg <= '0;
            held_address_reg   <= '0;
            captured_reg       <= 1'b0;
            coarse_reg         <= '{default: '0};
            volume_reg         <= '{default: '0};
            saved_reg          <= '{default: '0};
        end
        else
        begin
            running_status_reg <= running_status_next;
            held_address_reg   <= held_address_next;
            captured_reg       <= captured_next;
            coarse_reg         <= coarse_next;
            volume_reg         <= volume_next;
            saved_reg          <= saved_next;
        end
    end

endmodule

FILE: design/midi_cc_to_synth_params.sv
// Channel   | Signals                          | Role
// ----------+----------------------------------+------------------------------
// input     | in_valid, in_ready, midi_byte    | one MIDI byte per transfer
// output    | out_valid, out_ready, action,    | one parameter write per
//           | value                            | transfer
// config    | cfg_we, cfg_wdata                | control-change channel
//
// One byte per cycle sustained while the result is not stalled.
// A byte is taken into the input register, then is decoded against the
// parser state and lands in the result register.
// A stalled result holds the input register; input is still taken while that
// register is free. Reset clears all parser state and the channel to zero.
module midi_cc_to_synth_params (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  midi_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  action,
    output logic [10:0] value,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata
);

    logic               in_valid_reg;
    logic [7:0]         byte_reg;
    logic [3:0]         cc_channel_reg;
    logic               out_valid_reg;
    logic [4:0]         action_reg;
    logic [10:0]        value_reg;
    logic               advance;
    mccsp_pkg::result_t result;

    // Move a byte to the result stage when that stage is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    mccsp_param_unit u_param (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .midi_byte  (byte_reg),
        .cc_channel (cc_channel_reg),
        .result     (result)
    );

    // Channel register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_channel_reg <= '0;
        end
        else if (cfg_we)
        begin
            cc_channel_reg <= cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= midi_byte;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= result.hit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.hit)
        begin
            action_reg <= result.action;
            value_reg  <= result.value;
        end
    end

    assign out_valid = out_valid_reg;
    assign action    = action_reg;
    assign value     = value_reg;

`include "midi_cc_to_synth_params_assert.svh"

    `MCCSP_ASSERT_NEXT(a_hold_on_stall, in_valid_reg && out_valid_reg && !out_ready, in_valid_reg, "byte dropped while result stalled")
    `MCCSP_ASSERT_NOW(a_action_range, out_valid_reg, action_reg <= mccsp_pkg::ACT_CHORD_SLOT, "action out of range")
    `MCCSP_ASSERT_NOW(a_slot_range, out_valid_reg && action_reg == mccsp_pkg::ACT_CHORD_SLOT, value_reg <= 11'd7, "chord slot out of range")
    `MCCSP_ASSERT_NOW(a_volume_range, out_valid_reg && action_reg < mccsp_pkg::ACT_DUTY, value_reg <= 11'd15, "volume out of range")

endmodule

FILE: tb/midi_cc_to_synth_params_tb.sv
module midi_cc_to_synth_params_tb;

    // one parameter write as seen on the result channel
    typedef struct packed {
        mccsp_pkg::action_t act;
        logic [10:0]        val;
    } param_write_t;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } rx_mode_t;

    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 150;
    localparam int LONG_HOLD_CYCLES = 250;
    localparam int NUM_CORNERS = 14;
    localparam logic [6:0] CORNER_DATA [NUM_CORNERS] =
        '{7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd6, 7'd7, 7'd15, 7'd16,
          7'd62, 7'd63, 7'd64, 7'd65, 7'd127};

    // Parser model plus queue of parameter writes still owed by the block
    class param_scoreboard;
        logic [3:0]   cc_chan;
        logic [7:0]   run_status;
        logic [6:0]   held_addr;
        bit           addr_held;
        logic [10:0]  coarse [3];
        logic [3:0]   vol [4];
        logic [3:0]   vol_saved [4];
        param_write_t pending_writes [$];
        int unsigned  errors;

        function new();
            cc_chan = '0;
            run_status = '0;
            held_addr = '0;
            addr_held = 1'b0;
            foreach (coarse[i])
            begin
                coarse[i] = '0;
            end
            foreach (vol[i])
            begin
                vol[i] = '0;
                vol_saved[i] = '0;
            end
            errors = 0;
        endfunction

        function int unsigned clamp_to(int unsigned x, int unsigned hi);
            return (x > hi) ? hi : x;
        endfunction

        function void add_write(int unsigned a, int unsigned v);
            param_write_t w;
            w.act = a[4:0];
            w.val = v[10:0];
            pending_writes.push_back(w);
        endfunction

        // control change under the accepted channel
        function void decode_cc(logic [6:0] addr, logic [6:0] data);
            int unsigned v;
            int unsigned ch;
            int unsigned c;
            int unsigned f;
            v = 32'(data);
            if (addr >= mccsp_pkg::CC_VOL_FIRST && addr <= mccsp_pkg::CC_VOL_LAST)
            begin
                ch = 32'(addr - mccsp_pkg::CC_VOL_FIRST);
                vol[ch] = 4'(clamp_to(v, 32'(mccsp_pkg::VOL_MAX)));
                add_write(32'(mccsp_pkg::ACT_VOLUME) + ch, 32'(vol[ch]));
            end
            else if (addr >= mccsp_pkg::CC_DUTY_FIRST && addr <= mccsp_pkg::CC_DUTY_LAST)
            begin
                ch = 32'(addr - mccsp_pkg::CC_DUTY_FIRST);
                add_write(32'(mccsp_pkg::ACT_DUTY) + ch,
                          clamp_to(v, 32'(mccsp_pkg::DUTY_MAX)));
            end
            else if (addr == mccsp_pkg::CC_NOISE_RATIO)
            begin
                add_write(32'(mccsp_pkg::ACT_NOISE_RATIO),
                          clamp_to(v, 32'(mccsp_pkg::NOISE_RATIO_MAX)));
            end
            else if (addr >= mccsp_pkg::CC_COARSE_FIRST && addr <= mccsp_pkg::CC_COARSE_LAST)
            begin
                ch = 32'(addr - mccsp_pkg::CC_COARSE_FIRST);
                coarse[ch] = 11'(clamp_to(v * 16, 32'(mccsp_pkg::FREQ_MAX)));
                add_write(32'(mccsp_pkg::ACT_FREQ) + ch, 32'(coarse[ch]));
            end
            else if (addr == mccsp_pkg::CC_NOISE_FREQ)
            begin
                add_write(32'(mccsp_pkg::ACT_NOISE_FREQ),
                          clamp_to(v, 32'(mccsp_pkg::NOISE_FREQ_MAX)));
            end
            else if (addr >= mccsp_pkg::CC_FINE_FIRST && addr <= mccsp_pkg::CC_FINE_LAST)
            begin
                // offset around the center, pinned to 0..FREQ_MAX
                ch = 32'(addr - mccsp_pkg::CC_FINE_FIRST);
                c = 32'(coarse[ch]);
                if (v >= 32'(mccsp_pkg::FINE_MID))
                    f = clamp_to(c + v - 32'(mccsp_pkg::FINE_MID), 32'(mccsp_pkg::FREQ_MAX));
                else if (c >= 32'(mccsp_pkg::FINE_MID) - v)
                    f = c - (32'(mccsp_pkg::FINE_MID) - v);
                else
                    f = 0;
                add_write(32'(mccsp_pkg::ACT_FREQ) + ch, f);
            end
            else if (addr >= mccsp_pkg::CC_MUTE_FIRST && addr <= mccsp_pkg::CC_MUTE_LAST)
            begin
                // mute parks the volume, unmute brings it back
                ch = 32'(addr - mccsp_pkg::CC_MUTE_FIRST);
                if (v != 0)
                begin
                    vol_saved[ch] = vol[ch];
                    vol[ch] = '0;
                end
                else
                begin
                    vol[ch] = vol_saved[ch];
                end
                add_write(32'(mccsp_pkg::ACT_VOLUME) + ch, 32'(vol[ch]));
            end
            else
            begin
                case (addr)
                    mccsp_pkg::CC_WAVE_NEXT:
                    begin
                        if (v != 0)
                            add_write(32'(mccsp_pkg::ACT_WAVE_NEXT), 1);
                    end
                    mccsp_pkg::CC_NOISE_STEP:
                        add_write(32'(mccsp_pkg::ACT_NOISE_STEP), 32'(v != 0));
                    mccsp_pkg::CC_WAVE_RANGE:
                        add_write(32'(mccsp_pkg::ACT_WAVE_RANGE), 32'(v != 0));
                    mccsp_pkg::CC_REWIND:
                        add_write(32'(mccsp_pkg::ACT_REWIND), 0);
                    mccsp_pkg::CC_SEQ_RUN:
                        add_write(32'(mccsp_pkg::ACT_SEQ_RUN), 32'(v != 0));
                    mccsp_pkg::CC_CHORD_MODE:
                        add_write(32'(mccsp_pkg::ACT_CHORD_MODE), 32'(v != 0));
                    default:       ;
                endcase
            end
        endfunction

        // note-on picks a chord slot on the white keys only
        function void decode_key(logic [6:0] key);
            for (int i = 0; i < mccsp_pkg::NUM_KEYS; i++)
            begin
                if (mccsp_pkg::KEY_TABLE[i] == key)
                    add_write(32'(mccsp_pkg::ACT_CHORD_SLOT), 32'(i));
            end
        endfunction

        // called for every byte taken by the block
        function void note_byte(logic [7:0] b);
            if (b[7])
            begin
                if (b[7:4] != mccsp_pkg::KIND_SYSTEM)
                begin
                    run_status = b;
                    addr_held = 1'b0;
                end
            end
            else if (!addr_held)
            begin
                addr_held = 1'b1;
                held_addr = b[6:0];
            end
            else
            begin
                addr_held = 1'b0;
                if (run_status[7:4] == mccsp_pkg::KIND_CC)
                begin
                    if (run_status[3:0] == cc_chan)
                        decode_cc(held_addr, b[6:0]);
                end
                else if (run_status[7:4] == mccsp_pkg::KIND_NOTE_ON)
                begin
                    decode_key(held_addr);
                end
            end
        endfunction

        // called for every result taken from the block
        function void check_write(mccsp_pkg::action_t a, logic [10:0] v);
            param_write_t w;
            if (pending_writes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual action %0d value %0d",
                         $time, a, v);
                return;
            end
            w = pending_writes.pop_front();
            if (a !== w.act)
            begin
                errors++;
                $display("%0t: action mismatch: expected %0d, actual %0d",
                         $time, w.act, a);
            end
            if (v !== w.val)
            begin
                errors++;
                $display("%0t: value mismatch (action %0d): expected %0d, actual %0d",
                         $time, w.act, w.val, v);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  midi_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [4:0]  action;
    logic [10:0] value;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_wdata = '0;

    param_scoreboard sb = new();
    logic [7:0]  byte_stream [$];
    int unsigned item_count;
    logic [3:0]  gen_chan;
    int unsigned burst_left = 0;
    int unsigned gap_len;
    bit          long_hold_req = 1'b0;

    midi_cc_to_synth_params i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .midi_byte (midi_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .action    (action),
        .value     (value),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // hard stop
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------- stimulus building ----------------

    function automatic void push_byte(logic [7:0] b);
        byte_stream.push_back(b);
        if (b[7:4] != mccsp_pkg::KIND_SYSTEM)
            item_count++;
    endfunction

    function automatic logic [7:0] pick_data();
        if ($urandom_range(1) == 0)
            return {1'b0, CORNER_DATA[$urandom_range(NUM_CORNERS - 1)]};
        return 8'($urandom_range(127));
    endfunction

    function automatic logic [7:0] pick_cc_number();
        if ($urandom_range(99) < 85)
            return 8'($urandom_range(34));
        return 8'($urandom_range(127));
    endfunction

    function automatic logic [7:0] pick_key();
        if ($urandom_range(3) != 0)
            return {1'b0, mccsp_pkg::KEY_TABLE[$urandom_range(mccsp_pkg::NUM_KEYS - 1)]};
        return 8'($urandom_range(127));
    endfunction

    function automatic logic [7:0] pick_system();
        return {mccsp_pkg::KIND_SYSTEM, 4'($urandom_range(15))};
    endfunction

    // one message: mostly well-formed control changes, some notes, some junk
    function automatic void add_message();
        int unsigned pick;
        int unsigned n;
        logic [3:0]  ch;
        pick = $urandom_range(99);
        if (pick < 65)
        begin
            ch = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : gen_chan;
            if ($urandom_range(3) != 0)
                push_byte({mccsp_pkg::KIND_CC, ch});
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                push_byte(pick_cc_number());
                if ($urandom_range(15) == 0)
                    push_byte(pick_system());
                push_byte(pick_data());
            end
        end
        else if (pick < 80)
        begin
            push_byte({mccsp_pkg::KIND_NOTE_ON, 4'($urandom_range(15))});
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                push_byte(pick_key());
                push_byte(($urandom_range(4) == 0) ? 8'h00 : pick_data());
            end
        end
        else if (pick < 90)
        begin
            // any channel status kind 8..E with a data pair
            push_byte({4'($urandom_range(8, 14)), 4'($urandom_range(15))});
            push_byte(pick_data());
            push_byte(pick_data());
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n)
                push_byte(8'($urandom_range(255)));
        end
    endfunction

    function automatic void build_random_phase(int unsigned target);
        item_count = 0;
        while (item_count < target)
            add_message();
    endfunction

    function automatic void build_directed();
        logic [7:0] seq [$];
        // pair with no status since reset
        seq = '{8'h01, 8'h7F,
                8'hB0, 8'hF8,
                8'h01, 8'h7F,         // volume clamp
                8'h0D, 8'h00,         // fine below zero floor
                8'h09, 8'h7F,         // coarse top
                8'h0D, 8'h7F,         // fine above ceiling
                8'h15, 8'h01,         // mute
                8'h15, 8'h00,         // unmute
                8'h13, 8'h00,         // next wave with zero: nothing
                8'h13, 8'h01,
                8'h1D, 8'h40,         // rewind
                8'hB1, 8'h01, 8'h05,  // other channel
                8'h90, 8'h3C, 8'h00,  // note-on, zero velocity
                8'h48, 8'h7F,
                8'h3D, 8'h40,         // black key
                8'h80, 8'h3C, 8'h40}; // note-off
        foreach (seq[i])
            push_byte(seq[i]);
    endfunction

    // ---------------- drivers ----------------

    task automatic write_channel(input logic [3:0] ch);
        cfg_we <= 1'b1;
        cfg_wdata <= ch;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.cc_chan = ch;
    endtask

    // send queued bytes in bursts with random gaps
    task automatic send_stream();
        logic [7:0] b;
        while (byte_stream.size() != 0)
        begin
            b = byte_stream.pop_front();
            in_valid <= 1'b1;
            midi_byte <= b;
            do
                @(posedge clk);
            while (!in_ready);
            sb.note_byte(b);
            if (burst_left != 0)
                burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap_len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap_len != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap_len) @(posedge clk);
                end
            end
        end
        in_valid <= 1'b0;
    endtask

    // all results in, then let bytes with no result clear the pipe
    task automatic settle();
        while (sb.pending_writes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // ---------------- result side ----------------

    initial
    begin
        int unsigned hold_cnt;
        int unsigned mode_left;
        int unsigned rx_cycle;
        rx_mode_t    mode;
        hold_cnt = 0;
        mode_left = 0;
        rx_cycle = 0;
        mode = RX_ALWAYS;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rst_n && out_valid && out_ready)
                sb.check_write(action, value);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_cnt = LONG_HOLD_CYCLES;
            end
            if (hold_cnt != 0)
            begin
                hold_cnt--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(3));
                    mode_left = $urandom_range(10, 120);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS:  out_ready <= 1'b1;
                    RX_COIN:    out_ready <= ($urandom_range(1) == 0);
                    RX_SPARSE:  out_ready <= ($urandom_range(3) == 0);
                    RX_PATTERN: out_ready <= (rx_cycle[1:0] != 2'b00);
                    default:    out_ready <= 1'b1;
                endcase
            end
        end
    end

    // ---------------- main sequence ----------------

    initial
    begin
        logic [3:0] phase_chan [PHASES];
        phase_chan[0] = 4'd15;
        phase_chan[1] = 4'd0;
        phase_chan[2] = 4'($urandom_range(1, 14));
        phase_chan[3] = 4'd9;
        phase_chan[4] = 4'd15;
        phase_chan[5] = 4'($urandom_range(15));

        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_channel(4'd0);
        build_directed();
        send_stream();
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            write_channel(phase_chan[p]);
            gen_chan = phase_chan[p];
            build_random_phase(PHASE_ITEMS);
            // receiver backs off hard while the sender keeps pushing
            if (p == 0 || p == 3)
                long_hold_req = 1'b1;
            send_stream();
            settle();
        end

        if (sb.errors == 0 && sb.pending_writes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
